// File: sv/bcps_pkg.sv
`default_nettype none
package bcps_pkg;

  // Graph size
  localparam int NODES          = 16;
  localparam int EDGES_PER_NODE = 8;

  // Field widths fixed by the word format
  localparam int NODE_W = 4;
  localparam int BW_W   = 24;

  // Derived widths
  localparam int ADDR_W  = (NODES * EDGES_PER_NODE > 1) ? $clog2(NODES * EDGES_PER_NODE) : 1;
  localparam int CNT_W   = $clog2(EDGES_PER_NODE + 1);
  localparam int DEPTH_W = $clog2(NODES + 1);
  localparam int SIDX_W  = $clog2(NODES);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [BW_W-1:0]   bw_t;
  typedef logic [1:0]        status_t;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // Result status codes
  localparam status_t ST_STORED  = 2'd0;
  localparam status_t ST_DROPPED = 2'd1;
  localparam status_t ST_PATH    = 2'd2;
  localparam status_t ST_NOPATH  = 2'd3;

  // One stored edge
  typedef struct packed {
    node_t target;
    bw_t   bandwidth;
  } edge_t;

  // One search stack entry
  typedef struct packed {
    node_t            node;
    logic [CNT_W-1:0] cursor;
  } frame_t;

endpackage
`default_nettype wire

// File: sv/bcps_in_if.sv
`default_nettype none
interface bcps_in_if;
  import bcps_pkg::*;

  logic  valid;
  logic  ready;
  logic  command;
  node_t edge_from;
  node_t edge_to;
  bw_t   edge_bandwidth;
  node_t query_source;
  node_t query_dest;
  bw_t   min_bandwidth;

  modport source (
    output valid, command, edge_from, edge_to, edge_bandwidth,
           query_source, query_dest, min_bandwidth,
    input  ready
  );

  modport sink (
    input  valid, command, edge_from, edge_to, edge_bandwidth,
           query_source, query_dest, min_bandwidth,
    output ready
  );
endinterface
`default_nettype wire

// File: sv/bcps_out_if.sv
`default_nettype none
interface bcps_out_if;
  import bcps_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  node_t   path_node;
  logic    last;

  modport source (
    output valid, status, path_node, last,
    input  ready
  );

  modport sink (
    input  valid, status, path_node, last,
    output ready
  );
endinterface
`default_nettype wire

// File: sv/bandwidth_constrained_path_search_unit.sv
`default_nettype none
// Directed-graph store with a bandwidth-limited depth-first path search. An
// add-edge word yields one word (stored or dropped). A find-path word walks
// the graph through a one-port edge memory with a registered read: each edge
// examined passes S_STEP and S_EDGE, each backtrack S_STEP and S_POP, and
// each node of a found path S_OUT_RD and then S_OUT_EMIT or S_OUT_LAST. The
// search is bounded by the edge-memory read loop. One word is worked on at a
// time; the output register lets the next word in while the last result
// still waits. No clearing pass after reset.
module bandwidth_constrained_path_search_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bcps_in_if.sink     in_word,
  bcps_out_if.source  out_word
);
  import bcps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RESP, S_STEP, S_EDGE, S_POP, S_OUT_RD, S_OUT_EMIT, S_OUT_LAST
  } state_t;

  state_t              state_r;
  logic                out_valid_r;
  status_t             out_status_r;
  node_t               out_node_r;
  logic                out_last_r;
  status_t             resp_status_r;

  logic [CNT_W-1:0]    edge_count_r [NODES];
  logic [NODES-1:0]    visited_r;

  node_t               cur_r;
  logic [CNT_W-1:0]    cursor_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [DEPTH_W-1:0]  idx_r;
  node_t               dst_r;
  bw_t                 minbw_r;

  // Memories
  edge_t               edge_mem [NODES*EDGES_PER_NODE];
  edge_t               edge_q;
  frame_t              stack_mem [NODES];
  frame_t              stack_q;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  logic [SIDX_W-1:0]   cnt_addr;
  logic [CNT_W-1:0]    cnt_rd;
  logic                add_ok;
  logic [ADDR_W-1:0]   add_slot;
  logic [ADDR_W-1:0]   walk_slot;
  logic                edge_take;
  logic                src_ok;
  logic                edge_wr;
  logic                edge_rd;
  logic                stack_wr;
  logic                stack_rd;
  logic [SIDX_W-1:0]   stack_wr_addr;
  logic [SIDX_W-1:0]   stack_rd_addr;
  logic [DEPTH_W-1:0]  depth_m1;
  logic [DEPTH_W-1:0]  depth_m2;

  assign in_word.ready   = (state_r == S_IDLE);
  assign in_fire         = in_word.valid && in_word.ready;
  assign out_free        = !out_valid_r || out_word.ready;
  // Output register takes a new word in these states
  assign out_load        = out_free && (state_r inside {S_RESP, S_OUT_EMIT, S_OUT_LAST});

  assign out_word.valid     = out_valid_r;
  assign out_word.status    = out_status_r;
  assign out_word.path_node = out_node_r;
  assign out_word.last      = out_last_r;

  // Edge count lookup: source node of an add, else the node on top of stack
  assign cnt_addr = (state_r == S_IDLE) ? SIDX_W'(in_word.edge_from) : SIDX_W'(cur_r);
  assign cnt_rd   = edge_count_r[cnt_addr];

  assign add_ok = (32'(in_word.edge_from) < NODES) && (32'(in_word.edge_to) < NODES) &&
                  (32'(cnt_rd) < EDGES_PER_NODE);
  assign src_ok = (32'(in_word.query_source) < NODES) && (32'(in_word.query_dest) < NODES);

  assign add_slot  = ADDR_W'(in_word.edge_from) * ADDR_W'(EDGES_PER_NODE) + ADDR_W'(cnt_rd);
  assign walk_slot = ADDR_W'(cur_r) * ADDR_W'(EDGES_PER_NODE) + ADDR_W'(cursor_r);

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);

  // Edge is usable: valid target, not visited, enough bandwidth, stack room
  assign edge_take = (32'(edge_q.target) < NODES) && !visited_r[SIDX_W'(edge_q.target)] &&
                     (edge_q.bandwidth >= minbw_r) && (32'(depth_r) < NODES);

  // Memory controls
  assign edge_wr  = in_fire && (in_word.command == CMD_ADD) && add_ok;
  assign edge_rd  = (state_r == S_STEP) && (cur_r != dst_r) && (cursor_r < cnt_rd);
  assign stack_wr = (state_r == S_EDGE) && edge_take;
  assign stack_wr_addr = SIDX_W'(depth_m1);
  assign stack_rd = ((state_r == S_STEP) && (cur_r != dst_r) && !(cursor_r < cnt_rd) &&
                     (depth_r > DEPTH_W'(1))) ||
                    ((state_r == S_OUT_RD) && (idx_r != depth_m1));
  assign stack_rd_addr = (state_r == S_OUT_RD) ? SIDX_W'(idx_r) : SIDX_W'(depth_m2);

  // Edge memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (edge_wr) begin
      edge_mem[add_slot] <= '{target: in_word.edge_to, bandwidth: in_word.edge_bandwidth};
    end
    if (edge_rd) begin
      edge_q <= edge_mem[walk_slot];
    end
  end

  // Stack memory: frames below the top of stack
  always_ff @(posedge clk) begin
    if (stack_wr) begin
      stack_mem[stack_wr_addr] <= '{node: cur_r, cursor: cursor_r};
    end
    if (stack_rd) begin
      stack_q <= stack_mem[stack_rd_addr];
    end
  end

  // Control, search registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      visited_r   <= '0;
      depth_r     <= '0;
      for (int i = 0; i < NODES; i++) begin
        edge_count_r[i] <= '0;
      end
    end else begin
      // Output valid: set on a load, dropped once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_word.command == CMD_ADD) begin
              resp_status_r <= add_ok ? ST_STORED : ST_DROPPED;
              if (add_ok) begin
                edge_count_r[cnt_addr] <= cnt_rd + CNT_W'(1);
              end
              state_r <= S_RESP;
            end else begin
              dst_r     <= in_word.query_dest;
              minbw_r   <= in_word.min_bandwidth;
              if (src_ok) begin
                visited_r <= NODES'(1) << in_word.query_source;
                cur_r    <= in_word.query_source;
                cursor_r <= '0;
                depth_r  <= DEPTH_W'(1);
                state_r  <= S_STEP;
              end else begin
                visited_r     <= '0;
                depth_r       <= '0;
                resp_status_r <= ST_NOPATH;
                state_r       <= S_RESP;
              end
            end
          end
        end
        // Single-word reply
        S_RESP: begin
          if (out_free) begin
            out_status_r <= resp_status_r;
            out_node_r   <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        // Examine top of stack
        S_STEP: begin
          if (cur_r == dst_r) begin
            idx_r   <= '0;
            state_r <= S_OUT_RD;
          end else if (cursor_r < cnt_rd) begin
            cursor_r <= cursor_r + CNT_W'(1);
            state_r  <= S_EDGE;
          end else begin
            depth_r <= depth_m1;
            if (depth_r > DEPTH_W'(1)) begin
              state_r <= S_POP;
            end else begin
              resp_status_r <= ST_NOPATH;
              state_r       <= S_RESP;
            end
          end
        end
        // Edge data back from memory
        S_EDGE: begin
          if (edge_take) begin
            visited_r[SIDX_W'(edge_q.target)] <= 1'b1;
            cur_r    <= edge_q.target;
            cursor_r <= '0;
            depth_r  <= depth_r + DEPTH_W'(1);
          end
          state_r <= S_STEP;
        end
        // Parent frame back from memory
        S_POP: begin
          cur_r    <= stack_q.node;
          cursor_r <= stack_q.cursor;
          state_r  <= S_STEP;
        end
        // Path output: frames from the bottom, then the top node
        S_OUT_RD: begin
          state_r <= (idx_r == depth_m1) ? S_OUT_LAST : S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          if (out_free) begin
            out_status_r <= ST_PATH;
            out_node_r   <= stack_q.node;
            out_last_r   <= 1'b0;
            idx_r        <= idx_r + DEPTH_W'(1);
            state_r      <= S_OUT_RD;
          end
        end
        S_OUT_LAST: begin
          if (out_free) begin
            out_status_r <= ST_PATH;
            out_node_r   <= cur_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
